### rtl/mirror_dirty_region_log_core_macros.svh
// Assertion macros shared by the dirty-region log RTL.
`ifndef MIRROR_DIRTY_REGION_LOG_CORE_MACROS_SVH
`define MIRROR_DIRTY_REGION_LOG_CORE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define MDRL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define MDRL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define MDRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mdrl_pkg.sv
// Shared types, command codes and helper functions of the dirty-region log.
`timescale 1ns / 1ps

package mdrl_pkg;

    // Request commands.
    localparam logic [2:0] CMD_QUERY      = 3'd0;
    localparam logic [2:0] CMD_MARK_DIRTY = 3'd1;
    localparam logic [2:0] CMD_MARK_CLEAN = 3'd2;
    localparam logic [2:0] CMD_FETCH      = 3'd3;
    localparam logic [2:0] CMD_COMPLETE   = 3'd4;

    localparam int IN_W  = 16;
    localparam int OUT_W = 24;

    // One memory row covers 32 regions of each map.
    typedef struct packed {
        logic [31:0] rec;
        logic [31:0] sync;
        logic [31:0] clean;
    } row_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic reg_update;
        logic scan_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic fetch_go;
        logic scan_done;
        logic out_free;
    } dp_status_t;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [4:0] first_set(input logic [31:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

### rtl/mirror_dirty_region_log_core.sv
// Top level of the mirrored-volume dirty-region log.
`timescale 1ns / 1ps

// Channel  Direction  Payload                                            Transfer when
// s_*      in         tdata: cmd, region, success                        s_tvalid & s_tready
// m_*      out        tdata: clean, in_sync, work_region, synced_total   m_tvalid & m_tready
//                     tuser: work_found
// cfg_*    in         wr_data: regions_in_use                            cfg_wr_en
//
// Between the input transfer of a query, mark or completion request and the next
// input taken, the block reads the region's row, modifies and writes it back, and
// then loads the output register.
// A fetch also scans the 32-region rows one at a time before the output load, from
// the search pointer's row up to the row of the first free region or the last row
// below the region count, since the bitmap memory has a single read port.
// After reset a clearing pass writes every row, during which s_tready stays low;
// configuration writes are taken.
// A stalled result stays in the output register. One more request is still
// taken and processed, and it holds in its final cycle, with s_tready low,
// until that result has moved on.

module mirror_dirty_region_log_core #(
    parameter int MAX_REGIONS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [10:0]                cfg_wr_data,   // regions_in_use
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mdrl_pkg::IN_W-1:0]  s_tdata,       // cmd[2:0], region[12:3], success[13]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mdrl_pkg::OUT_W-1:0] m_tdata,       // region_clean[0], region_in_sync[1],
                                                      // work_region[11:2], synced_total[22:12]
    output logic [0:0]                 m_tuser        // work_found[0]
);

    mdrl_pkg::ctrl_cmd_t  ctrl_cmd;
    mdrl_pkg::dp_status_t dp_status;

    // Request fields as they sit in the input transfer.
    logic [2:0] in_cmd;
    logic [9:0] in_region;
    logic       in_success;

    assign in_cmd     = s_tdata[2:0];
    assign in_region  = s_tdata[12:3];
    assign in_success = s_tdata[13];

    // The controller sequences each request; the datapath holds the bitmaps,
    // the search pointer, the synced count and the output register.
    mdrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status_i (dp_status),
        .cmd_o    (ctrl_cmd)
    );

    mdrl_datapath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (in_cmd),
        .in_region   (in_region),
        .in_success  (in_success),
        .cmd_i       (ctrl_cmd),
        .status_o    (dp_status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### rtl/mdrl_ctrl.sv
// Sequencing state machine of the dirty-region log.
`timescale 1ns / 1ps

module mdrl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mdrl_pkg::dp_status_t status_i,
    output mdrl_pkg::ctrl_cmd_t  cmd_o
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_REG   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd_o.clr_step = 1'b1;
                if (status_i.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_o.accept = 1'b1;
                    state_next   = ST_REG;
                end
            end
            ST_REG:
            begin
                cmd_o.reg_update = 1'b1;
                state_next = status_i.fetch_go ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                cmd_o.scan_step = 1'b1;
                if (status_i.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status_i.out_free)
                begin
                    cmd_o.load_out = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/mdrl_datapath.sv
// Bitmap memory, search pointer, counters and result register of the dirty-region log.
`timescale 1ns / 1ps
`include "mirror_dirty_region_log_core_macros.svh"

module mdrl_datapath #(
    parameter int MAX_REGIONS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [10:0]               cfg_wr_data,
    input  logic [2:0]                in_cmd,
    input  logic [9:0]                in_region,
    input  logic                      in_success,
    input  mdrl_pkg::ctrl_cmd_t       cmd_i,
    output mdrl_pkg::dp_status_t      status_o,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [mdrl_pkg::OUT_W-1:0] m_tdata,
    output logic [0:0]                m_tuser
);

    localparam int WORDS = (MAX_REGIONS + 31) / 32;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(MAX_REGIONS + 1);
    localparam logic [31:0] MAX_W = 32'(MAX_REGIONS);

    mdrl_pkg::row_t mem [0:WORDS-1];
    mdrl_pkg::row_t rd_data_reg;
    mdrl_pkg::row_t wr_data;
    mdrl_pkg::row_t upd_row;
    mdrl_pkg::row_t hit_row;
    mdrl_pkg::row_t clear_row;
    logic           rd_en;
    logic [WAW-1:0] rd_addr;
    logic           wr_en;
    logic [WAW-1:0] wr_addr;

    logic [10:0]    regions_reg;
    logic [10:0]    regions_next;
    logic [PW-1:0]  count;
    logic [PW-1:0]  sp_reg;
    logic [PW-1:0]  sp_next;
    logic [PW-1:0]  synced_reg;
    logic [PW-1:0]  synced_next;
    logic [WAW-1:0] w_reg;
    logic [WAW-1:0] w_next;
    logic           first_reg;
    logic           first_next;
    logic [WAW-1:0] clr_reg;
    logic [WAW-1:0] clr_next;

    logic [2:0]     cmd_reg;
    logic [9:0]     region_reg;
    logic           success_reg;

    logic           res_clean_reg;
    logic           res_clean_next;
    logic           res_sync_reg;
    logic           res_sync_next;
    logic           found_reg;
    logic           found_next;
    logic [9:0]     work_reg;
    logic [9:0]     work_next;
    logic [10:0]    total_reg;
    logic [10:0]    total_next;

    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [mdrl_pkg::OUT_W-1:0] m_tdata_reg;
    logic [mdrl_pkg::OUT_W-1:0] m_tdata_next;
    logic                      m_tuser_reg;
    logic                      m_tuser_next;

    logic [PW+9:0]  in_region_ext;
    logic [PW+9:0]  reg_region_ext;
    logic [PW+9:0]  sp_ext;
    logic [PW+9:0]  cnt_ext;
    logic [PW+4:0]  w_ext;
    logic [PW+10:0] syn_ext;
    logic [WAW-1:0] in_word;
    logic [WAW-1:0] reg_word;
    logic [WAW-1:0] sp_word;
    logic [4:0]     bit_idx;
    logic           in_valid;
    logic           region_valid;
    logic           reg_wr;
    logic           inc;

    logic [31:0]    lo_mask;
    logic [31:0]    hi_mask;
    logic [31:0]    free_bits;
    logic           scan_hit;
    logic           scan_end;
    logic [4:0]     hit_idx;
    logic [PW+5:0]  hit_pos;
    logic [PW+5:0]  sp_hit;
    logic [PW+5:0]  next_start;

    // The region count in use is the register saturated at the map size.
    always_comb
    begin
        if ({21'd0, regions_reg} > MAX_W)
        begin
            count = MAX_W[PW-1:0];
        end
        else
        begin
            count = PW'(regions_reg);
        end
    end

    assign in_region_ext  = (PW + 10)'(in_region);
    assign reg_region_ext = (PW + 10)'(region_reg);
    assign sp_ext         = (PW + 10)'(sp_reg);
    assign cnt_ext        = (PW + 10)'(count);
    assign w_ext          = (PW + 5)'(w_reg);
    assign in_word        = in_region_ext[WAW+4:5];
    assign reg_word       = reg_region_ext[WAW+4:5];
    assign sp_word        = sp_ext[WAW+4:5];
    assign bit_idx        = region_reg[4:0];
    assign in_valid       = {22'd0, in_region} < MAX_W;
    assign region_valid   = {22'd0, region_reg} < MAX_W;

    assign clear_row.clean = '1;
    assign clear_row.sync  = '0;
    assign clear_row.rec   = '0;

    // Scan of one row: free regions are neither in sync nor recovering and lie
    // between the search pointer and the region count.
    assign lo_mask    = first_reg ? (32'hFFFF_FFFF << sp_reg[4:0]) : 32'hFFFF_FFFF;
    assign hi_mask    = (w_ext == cnt_ext[PW+9:5]) ? ~(32'hFFFF_FFFF << count[4:0])
                                                  : 32'hFFFF_FFFF;
    assign free_bits  = ~(rd_data_reg.sync | rd_data_reg.rec) & lo_mask & hi_mask;
    assign scan_hit   = |free_bits;
    assign hit_idx    = mdrl_pkg::first_set(free_bits);
    assign hit_pos    = (PW + 6)'({w_reg, hit_idx});
    assign sp_hit     = hit_pos + (PW + 6)'(1);
    assign next_start = ((PW + 6)'(w_reg) + (PW + 6)'(1)) << 5;
    assign scan_end   = next_start >= (PW + 6)'(count);

    always_comb
    begin
        hit_row              = rd_data_reg;
        hit_row.rec[hit_idx] = 1'b1;
    end

    // Read-modify-write of the addressed region's row.
    always_comb
    begin
        upd_row = rd_data_reg;
        reg_wr  = 1'b0;
        inc     = 1'b0;
        case (cmd_reg)
            mdrl_pkg::CMD_MARK_DIRTY:
            begin
                upd_row.clean[bit_idx] = 1'b0;
                reg_wr = region_valid;
            end
            mdrl_pkg::CMD_MARK_CLEAN:
            begin
                upd_row.clean[bit_idx] = 1'b1;
                reg_wr = region_valid;
            end
            mdrl_pkg::CMD_COMPLETE:
            begin
                upd_row.rec[bit_idx] = 1'b0;
                if (success_reg)
                begin
                    upd_row.sync[bit_idx] = 1'b1;
                    inc = region_valid && (synced_reg < count);
                end
                reg_wr = region_valid;
            end
            default:
            begin
                reg_wr = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = in_word;
        wr_en          = 1'b0;
        wr_addr        = clr_reg;
        wr_data        = clear_row;
        regions_next   = cfg_wr_en ? cfg_wr_data : regions_reg;
        sp_next        = sp_reg;
        synced_next    = synced_reg;
        w_next         = w_reg;
        first_next     = first_reg;
        clr_next       = clr_reg;
        res_clean_next = res_clean_reg;
        res_sync_next  = res_sync_reg;
        found_next     = found_reg;
        work_next      = work_reg;
        total_next     = total_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        syn_ext        = (PW + 11)'(synced_reg);

        if (cmd_i.clr_step)
        begin
            wr_en    = 1'b1;
            clr_next = clr_reg + WAW'(1);
        end

        if (cmd_i.accept)
        begin
            rd_en   = in_valid;
            rd_addr = in_word;
        end

        if (cmd_i.reg_update)
        begin
            wr_en   = reg_wr;
            wr_addr = reg_word;
            wr_data = upd_row;
            if (inc)
            begin
                synced_next = synced_reg + PW'(1);
            end
            syn_ext        = (PW + 11)'(synced_next);
            total_next     = syn_ext[10:0];
            res_clean_next = region_valid && upd_row.clean[bit_idx];
            res_sync_next  = region_valid && upd_row.sync[bit_idx];
            found_next     = 1'b0;
            work_next      = 10'd0;
            if (status_o.fetch_go)
            begin
                rd_en      = 1'b1;
                rd_addr    = sp_word;
                w_next     = sp_word;
                first_next = 1'b1;
            end
        end

        if (cmd_i.scan_step)
        begin
            if (scan_hit)
            begin
                wr_en      = 1'b1;
                wr_addr    = w_reg;
                wr_data    = hit_row;
                sp_next    = sp_hit[PW-1:0];
                found_next = 1'b1;
                work_next  = hit_pos[9:0];
            end
            else if (scan_end)
            begin
                sp_next = count;
            end
            else
            begin
                rd_en      = 1'b1;
                rd_addr    = w_reg + WAW'(1);
                w_next     = w_reg + WAW'(1);
                first_next = 1'b0;
            end
        end

        if (cmd_i.load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, total_reg, work_reg, res_sync_reg, res_clean_reg};
            m_tuser_next  = found_reg;
        end
    end

    assign status_o.clr_last  = (clr_reg == WAW'(WORDS - 1));
    assign status_o.fetch_go  = (cmd_reg == mdrl_pkg::CMD_FETCH) && (sp_reg < count);
    assign status_o.scan_done = scan_hit || scan_end;
    assign status_o.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regions_reg  <= 11'd1024;
            sp_reg       <= '0;
            synced_reg   <= '0;
            w_reg        <= '0;
            first_reg    <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            regions_reg  <= regions_next;
            sp_reg       <= sp_next;
            synced_reg   <= synced_next;
            w_reg        <= w_next;
            first_reg    <= first_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.accept)
        begin
            cmd_reg     <= in_cmd;
            region_reg  <= in_region;
            success_reg <= in_success;
        end
        res_clean_reg <= res_clean_next;
        res_sync_reg  <= res_sync_next;
        found_reg     <= found_next;
        work_reg      <= work_next;
        total_reg     <= total_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    `MDRL_ASSERT_IMPL(a_hit_below_count, cmd_i.scan_step && scan_hit, hit_pos < (PW + 6)'(count), "handed-out region lies at or above the region count")
    `MDRL_ASSERT_NEXT(a_pointer_forward, 1'b1, sp_reg >= $past(sp_reg), "search pointer moved back")
    `MDRL_ASSERT_NEXT(a_count_step, 1'b1, (synced_reg == $past(synced_reg)) || (synced_reg == $past(synced_reg) + PW'(1)), "synced count changed by more than one")

endmodule

### test/mdrl_checker.sv
// Scoreboard for the dirty-region log: tracks the bitmaps, predicts each result and compares.
`timescale 1ns / 1ps

module mdrl_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [10:0]                cfg_wr_data,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [mdrl_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [mdrl_pkg::OUT_W-1:0] m_tdata,
    input  logic [0:0]                 m_tuser,
    output int                         pending_results,
    output int                         fail_count
);

    localparam int NUM_REGIONS = 1024;

    typedef struct packed {
        logic       clean;
        logic       in_sync;
        logic       found;
        logic [9:0] work;
        logic [10:0] total;
    } log_result_t;

    logic        clean_flags [NUM_REGIONS];
    logic        sync_flags [NUM_REGIONS];
    logic        rec_flags [NUM_REGIONS];
    logic [10:0] scan_ptr;
    logic [10:0] synced_cnt;
    logic [10:0] region_limit;
    log_result_t expected_results [$];
    int          outstanding = 0;
    int          fails = 0;

    assign pending_results = outstanding;
    assign fail_count = fails;

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            report($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    // Applies one request to the tracked maps and returns the result it should produce.
    task automatic apply_request(input logic [2:0] op, input logic [9:0] idx, input logic ok,
                                 output log_result_t res);
        logic [10:0] span;
        int          i;
        logic        hit;
        logic [9:0]  got;
        span = (region_limit > 11'd1024) ? 11'd1024 : region_limit;
        hit = 1'b0;
        got = '0;
        case (op)
            mdrl_pkg::CMD_MARK_DIRTY: clean_flags[idx] = 1'b0;
            mdrl_pkg::CMD_MARK_CLEAN: clean_flags[idx] = 1'b1;
            mdrl_pkg::CMD_FETCH:
            begin
                i = scan_ptr;
                while (i < span && !hit)
                begin
                    if (!sync_flags[i])
                    begin
                        scan_ptr = 11'(i + 1);
                        if (!rec_flags[i])
                        begin
                            rec_flags[i] = 1'b1;
                            hit = 1'b1;
                            got = 10'(i);
                        end
                    end
                    i++;
                end
                if (!hit && scan_ptr < span)
                begin
                    scan_ptr = span;
                end
            end
            mdrl_pkg::CMD_COMPLETE:
            begin
                rec_flags[idx] = 1'b0;
                if (ok)
                begin
                    sync_flags[idx] = 1'b1;
                    if (synced_cnt < span)
                    begin
                        synced_cnt = synced_cnt + 11'd1;
                    end
                end
            end
            default: ;
        endcase
        res.clean = clean_flags[idx];
        res.in_sync = sync_flags[idx];
        res.found = hit;
        res.work = got;
        res.total = synced_cnt;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        log_result_t want;
        log_result_t seen;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGIONS; k++)
            begin
                clean_flags[k] = 1'b1;
                sync_flags[k] = 1'b0;
                rec_flags[k] = 1'b0;
            end
            scan_ptr = '0;
            synced_cnt = '0;
            region_limit = 11'd1024;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                region_limit = cfg_wr_data;
            end
            if (m_tvalid && m_tready)
            begin
                seen.clean = m_tdata[0];
                seen.in_sync = m_tdata[1];
                seen.work = m_tdata[11:2];
                seen.total = m_tdata[22:12];
                seen.found = m_tuser[0];
                if (expected_results.size() == 0)
                begin
                    report("result transfer with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    outstanding--;
                    check_field("region_clean", want.clean, seen.clean);
                    check_field("region_in_sync", want.in_sync, seen.in_sync);
                    check_field("work_found", want.found, seen.found);
                    check_field("work_region", want.work, seen.work);
                    check_field("synced_total", want.total, seen.total);
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tdata[2:0], s_tdata[12:3], s_tdata[13], want);
                expected_results.push_back(want);
                outstanding++;
            end
        end
    end

endmodule

### test/tb_mirror_dirty_region_log_core.sv
// Testbench top for the dirty-region log: request stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module tb_mirror_dirty_region_log_core;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [10:0]                   cfg_wr_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mdrl_pkg::IN_W-1:0]     s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b1;
    logic [mdrl_pkg::OUT_W-1:0]    m_tdata;
    logic [0:0]                    m_tuser;
    int                            pending_results;
    int                            fail_count;

    // Idle bursts on both channels are enabled per phase; the final phase runs flat out.
    logic                idle_on = 1'b1;

    // Regions handed out by fetches, so that most completions close real resync work.
    logic [9:0]          handed_out [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mirror_dirty_region_log_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    mdrl_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    // Hard stop well beyond the slowest legal run, including the clearing pass after reset.
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // Record every region the block hands out for resync.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready && m_tuser[0])
        begin
            handed_out.push_back(m_tdata[11:2]);
        end
    end

    // Output-side back-pressure: random stall bursts while idling is on.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && rst_n && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Presents one request and returns on the falling edge after its transfer. Valid is left
    // high so that back-to-back requests stream without a bubble; a gap burst lowers it first.
    task automatic send_request(input logic [2:0] op, input logic [9:0] idx, input logic ok);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, ok, idx, op};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    // The region count may only change while the block is idle, so the input is closed
    // and every outstanding result has to drain before the write.
    task automatic set_region_limit(input logic [10:0] limit);
        s_tvalid <= 1'b0;
        wait (pending_results == 0);
        repeat (4) @(negedge clk);
        cfg_wr_data <= limit;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Regions lean toward both ends of the map and toward the low rows where fetches work.
    function automatic logic [9:0] pick_region();
        case ($urandom_range(0, 9))
            0:       return 10'd0;
            1:       return 10'd1023;
            2, 3:    return 10'($urandom_range(0, 63));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // One random request. Fetch and completion dominate so that resync work flows through
    // the recovering state; most completions close a region that was actually handed out.
    task automatic random_request();
        int          roll;
        logic [9:0]  idx;
        logic        ok;
        roll = $urandom_range(0, 99);
        idx = pick_region();
        ok = ($urandom_range(0, 3) != 0);
        if (roll < 22)
        begin
            send_request(mdrl_pkg::CMD_FETCH, idx, 1'($urandom_range(0, 1)));
        end
        else if (roll < 48)
        begin
            if (handed_out.size() != 0 && $urandom_range(0, 4) != 0)
            begin
                idx = handed_out.pop_front();
            end
            send_request(mdrl_pkg::CMD_COMPLETE, idx, ok);
        end
        else if (roll < 66)
        begin
            send_request(mdrl_pkg::CMD_MARK_DIRTY, idx, 1'($urandom_range(0, 1)));
        end
        else if (roll < 80)
        begin
            send_request(mdrl_pkg::CMD_MARK_CLEAN, idx, 1'($urandom_range(0, 1)));
        end
        else if (roll < 92)
        begin
            send_request(mdrl_pkg::CMD_QUERY, idx, 1'($urandom_range(0, 1)));
        end
        else
        begin
            // Undefined command codes must act as a query.
            send_request(3'($urandom_range(mdrl_pkg::CMD_COMPLETE + 1, 7)), idx,
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        logic [10:0] phase_limits [5];
        phase_limits[0] = 11'd64;
        phase_limits[1] = 11'd1;
        phase_limits[2] = 11'd1024;
        phase_limits[3] = 11'd2047;
        phase_limits[4] = 11'($urandom_range(1, 2047));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The write lands during the clearing pass, which is allowed.
        set_region_limit(11'd1024);

        // Directed part: field extremes, every command, and the corner cases of the log.
        send_request(mdrl_pkg::CMD_QUERY, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_QUERY, 10'd1023, 1'b1);
        send_request(mdrl_pkg::CMD_MARK_DIRTY, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_MARK_DIRTY, 10'd1023, 1'b0);
        send_request(mdrl_pkg::CMD_MARK_CLEAN, 10'd1023, 1'b1);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_COMPLETE, 10'd0, 1'b1);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        // A failed resync clears recovering only; the pointer has already moved past it.
        send_request(mdrl_pkg::CMD_COMPLETE, 10'd1, 1'b0);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        // Completions of a region never handed out and of one already in sync still count.
        send_request(mdrl_pkg::CMD_COMPLETE, 10'd5, 1'b1);
        send_request(mdrl_pkg::CMD_COMPLETE, 10'd0, 1'b1);
        send_request(mdrl_pkg::CMD_COMPLETE + 3'd1, 10'd7, 1'b0);
        send_request(mdrl_pkg::CMD_COMPLETE + 3'd2, 10'd0, 1'b0);
        send_request(3'd7, 10'd1023, 1'b1);

        // A small count: the search runs off the end and the synced count saturates.
        set_region_limit(11'd4);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_COMPLETE, 10'd10, 1'b1);
        send_request(mdrl_pkg::CMD_COMPLETE, 10'd11, 1'b1);

        // Zero regions: nothing is found and nothing more is counted.
        set_region_limit(11'd0);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_COMPLETE, 10'd12, 1'b1);

        // A count above the map size saturates; the search resumes where it stopped.
        set_region_limit(11'd2047);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_FETCH, 10'd0, 1'b0);
        send_request(mdrl_pkg::CMD_MARK_CLEAN, 10'd0, 1'b0);

        // Random part in five phases of different region counts; the last runs without idling.
        for (int p = 0; p < 5; p++)
        begin
            set_region_limit(phase_limits[p]);
            idle_on = (p != 4);
            repeat (110) random_request();
        end

        s_tvalid <= 1'b0;
        wait (pending_results == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
